@@ rtl/dpm_pkg.sv @@
// Shared widths, constants and payload types for the posterior-mean core.
// No dependencies; every other file but dpm_stream_if imports this package.
package dpm_pkg;

    localparam int SMP_W     = 32;        // signed Q8.24 samples
    localparam int SCH_W     = 31;        // unsigned Q1.30 schedule values
    localparam int FRAC_Q30  = 30;        // fraction bits of Q1.30
    localparam int SQRT_BITS = 31;        // root bits, radicand is twice as wide
    localparam int DIV_DW    = 63;        // dividend / quotient bits
    localparam int DIV_VW    = SCH_W;     // divisor bits

    localparam logic [SCH_W-1:0] ONE_Q30 = SCH_W'(1) << FRAC_Q30;

    typedef struct packed {
        logic signed [SMP_W-1:0] noisy_sample;
        logic signed [SMP_W-1:0] predicted_noise;
        logic        [SCH_W-1:0] sqrt_abar_now;
        logic        [SCH_W-1:0] sqrt_abar_prev;
        logic        [SCH_W-1:0] noise_rate;
        logic        [SCH_W-1:0] one_minus_abar_now;
        logic        [SCH_W-1:0] one_minus_abar_prev;
    } t_dpm_in;

    typedef struct packed {
        logic signed [SMP_W-1:0] posterior_mean;
        logic                    saturated;
        logic                    divide_error;
    } t_dpm_out;

    // carried alongside the square-root pipeline
    typedef struct packed {
        logic signed [SMP_W-1:0] x;
        logic signed [SMP_W-1:0] eps;
        logic        [SCH_W-1:0] sa;
        logic        [SCH_W-1:0] sp;
        logic        [SCH_W-1:0] beta;
        logic        [SCH_W-1:0] om;
        logic        [SCH_W-1:0] omp;
        logic                    dz;
    } t_dpm_sq_side;

    // carried alongside the divider pipeline
    typedef struct packed {
        logic                    neg_num;
        logic signed [SMP_W-1:0] x;
        logic                    dz;
    } t_dpm_dv_side;

    // operands handed to the multiply / round / clip tail
    typedef struct packed {
        logic        [DIV_DW-1:0] x0_mag;
        logic        [DIV_DW-1:0] c1;
        logic        [DIV_DW-1:0] c2;
        logic                     neg_x0;
        logic signed [SMP_W-1:0]  x;
        logic                     dz;
    } t_dpm_tail_op;

endpackage

@@ rtl/dpm_stream_if.sv @@
// Valid/ready stream channel carrying one item of type T.
// No dependencies.
interface dpm_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/dpm_isqrt.sv @@
// Pipelined integer square root, one root bit per stage, several lanes in step.
// Depends on dpm_pkg.
module dpm_isqrt import dpm_pkg::*; #(
    parameter int RW = SQRT_BITS,
    parameter int NL = 2,
    parameter int SW = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [NL-1:0][2*RW-1:0]    i_rad,
    input  logic [SW-1:0]              i_side,
    output logic                       o_valid,
    output logic [NL-1:0][RW-1:0]      o_root,
    output logic [SW-1:0]              o_side
);

    localparam int RDW = 2 * RW;

    logic                      r_v    [RW];
    logic [NL-1:0][RW-1:0]     r_root [RW];
    logic [NL-1:0][RDW-1:0]    r_rem  [RW-1];
    logic [SW-1:0]             r_side [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int BI = RW - 1 - k;

        logic                   w_v;
        logic [SW-1:0]          w_side;
        logic [NL-1:0][RW-1:0]  w_root;
        logic [NL-1:0][RW-1:0]  n_root;
        logic [NL-1:0][RDW-1:0] w_rem;
        logic [NL-1:0][RDW-1:0] n_rem;
        logic [NL-1:0][RDW-1:0] w_trial;

        if (k == 0) begin : g_head
            assign w_v    = i_valid;
            assign w_side = i_side;
            assign w_root = '0;
            assign w_rem  = i_rad;
        end else begin : g_body
            assign w_v    = r_v[k-1];
            assign w_side = r_side[k-1];
            assign w_root = r_root[k-1];
            assign w_rem  = r_rem[k-1];
        end

        // (q + 2^b)^2 - q^2 = q*2^(b+1) + 2^(2b); rem tracks rad - q^2
        always_comb begin
            for (int l = 0; l < NL; l++) begin
                w_trial[l] = ({{RW{1'b0}}, w_root[l]} << (BI + 1)) + (RDW'(1) << (2 * BI));
                if (w_rem[l] >= w_trial[l]) begin
                    n_rem[l]  = w_rem[l] - w_trial[l];
                    n_root[l] = w_root[l] | (RW'(1) << BI);
                end else begin
                    n_rem[l]  = w_rem[l];
                    n_root[l] = w_root[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= n_root;
                r_side[k] <= w_side;
            end
        end

        if (k < RW - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                end
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

@@ rtl/dpm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, several lanes in step.
// Depends on dpm_pkg.
module dpm_div import dpm_pkg::*; #(
    parameter int DW = DIV_DW,
    parameter int VW = DIV_VW,
    parameter int NL = 3,
    parameter int SW = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [NL-1:0][DW-1:0]  i_dvd,
    input  logic [NL-1:0][VW-1:0]  i_dvs,
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    output logic [NL-1:0][DW-1:0]  o_quo,
    output logic [SW-1:0]          o_side
);

    localparam int AW = VW + DW;    // {remainder, dividend/quotient}

    logic                   r_v    [DW];
    logic [NL-1:0][AW-1:0]  r_acc  [DW];
    logic [NL-1:0][VW-1:0]  r_dvs  [DW-1];
    logic [SW-1:0]          r_side [DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic                   w_v;
        logic [SW-1:0]          w_side;
        logic [NL-1:0][AW-1:0]  w_acc;
        logic [NL-1:0][AW-1:0]  n_acc;
        logic [NL-1:0][VW-1:0]  w_dvs;
        logic [NL-1:0][AW:0]    w_sh;
        logic [NL-1:0][VW:0]    w_hi;
        logic [NL-1:0][VW:0]    w_hin;
        logic [NL-1:0]          w_ge;

        if (k == 0) begin : g_head
            assign w_v    = i_valid;
            assign w_side = i_side;
            assign w_dvs  = i_dvs;
            always_comb begin
                for (int l = 0; l < NL; l++) begin
                    w_acc[l] = {{VW{1'b0}}, i_dvd[l]};
                end
            end
        end else begin : g_body
            assign w_v    = r_v[k-1];
            assign w_side = r_side[k-1];
            assign w_dvs  = r_dvs[k-1];
            assign w_acc  = r_acc[k-1];
        end

        // quotient bits shift in at the bottom as dividend bits leave the top
        always_comb begin
            for (int l = 0; l < NL; l++) begin
                w_sh[l]  = {w_acc[l], 1'b0};
                w_hi[l]  = w_sh[l][AW:DW];
                w_ge[l]  = w_hi[l] >= {1'b0, w_dvs[l]};
                w_hin[l] = w_ge[l] ? (w_hi[l] - {1'b0, w_dvs[l]}) : w_hi[l];
                n_acc[l] = {w_hin[l][VW-1:0], w_sh[l][DW-1:1], w_ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k]  <= n_acc;
                r_side[k] <= w_side;
            end
        end

        if (k < DW - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dvs[k] <= w_dvs;
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            o_quo[l] = r_acc[DW-1][l][DW-1:0];
        end
    end

    assign o_valid = r_v[DW-1];
    assign o_side  = r_side[DW-1];

endmodule

@@ rtl/dpm_tail.sv @@
// Final combine: c1*x0 + c2*x from 32-bit partial products, then round, clip
// and flag. Nine register stages, the last one is the output register. Uses dpm_pkg.
module dpm_tail import dpm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  t_dpm_tail_op i_op,
    output logic         o_valid,
    output t_dpm_out     o_res
);

    localparam int NSTG = 9;
    localparam int ACW  = 128;
    localparam int QW   = ACW - FRAC_Q30;
    localparam int HW   = DIV_DW - 32;     // high limb bits of a quotient

    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        mul32 = {32'b0, a} * {32'b0, b};
    endfunction

    logic [NSTG-1:0] r_v;

    // T1
    logic [SMP_W-1:0]  r_t1_ax;
    logic [DIV_DW-1:0] r_t1_x0, r_t1_c1, r_t1_c2;
    logic              r_t1_neg1, r_t1_neg2, r_t1_dz;
    // T2
    logic [63:0]       r_t2_a00, r_t2_a01, r_t2_a10, r_t2_a11, r_t2_b0, r_t2_b1;
    logic              r_t2_neg1, r_t2_neg2, r_t2_dz;
    // T3
    logic [64:0]       r_t3_mid;
    logic [95:0]       r_t3_t2;
    logic [63:0]       r_t3_a00, r_t3_a11;
    logic              r_t3_neg1, r_t3_neg2, r_t3_dz;
    // T4
    logic [ACW-1:0]    r_t4_t1;
    logic [95:0]       r_t4_t2;
    logic              r_t4_neg1, r_t4_neg2, r_t4_dz;
    // T5..T8
    logic [ACW-1:0]    r_t5_s1, r_t5_s2, r_t6_acc, r_t7_mag, r_t8_rnd;
    logic              r_t5_dz, r_t6_dz, r_t7_dz, r_t8_dz;
    logic              r_t7_neg, r_t8_neg;
    // T9
    t_dpm_out          r_out;

    logic [SMP_W-1:0]  w_ax;
    logic [QW-1:0]     w_q;
    logic [QW-1:0]     w_lim;
    logic              w_sat;
    logic [SMP_W-1:0]  w_mag;
    t_dpm_out          n_out;

    assign w_ax = i_op.x[SMP_W-1] ? (~i_op.x + 1'b1) : i_op.x;

    always_comb begin
        w_q   = r_t8_rnd[ACW-1:FRAC_Q30];
        w_lim = r_t8_neg ? QW'(64'h8000_0000) : QW'(64'h7FFF_FFFF);
        w_sat = w_q > w_lim;
        w_mag = w_sat ? w_lim[SMP_W-1:0] : w_q[SMP_W-1:0];
        if (r_t8_dz) begin
            n_out.posterior_mean = '0;
            n_out.saturated      = 1'b0;
            n_out.divide_error   = 1'b1;
        end else begin
            n_out.posterior_mean = r_t8_neg ? (~w_mag + 1'b1) : w_mag;
            n_out.saturated      = w_sat;
            n_out.divide_error   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1_ax   <= w_ax;
            r_t1_x0   <= i_op.x0_mag;
            r_t1_c1   <= i_op.c1;
            r_t1_c2   <= i_op.c2;
            r_t1_neg1 <= i_op.neg_x0;
            r_t1_neg2 <= i_op.x[SMP_W-1];
            r_t1_dz   <= i_op.dz;

            r_t2_a00  <= mul32(r_t1_c1[31:0], r_t1_x0[31:0]);
            r_t2_a01  <= mul32(r_t1_c1[31:0], {1'b0, r_t1_x0[DIV_DW-1:32]});
            r_t2_a10  <= mul32({1'b0, r_t1_c1[DIV_DW-1:32]}, r_t1_x0[31:0]);
            r_t2_a11  <= mul32({{(32-HW){1'b0}}, r_t1_c1[DIV_DW-1:32]},
                               {{(32-HW){1'b0}}, r_t1_x0[DIV_DW-1:32]});
            r_t2_b0   <= mul32(r_t1_c2[31:0], r_t1_ax);
            r_t2_b1   <= mul32({1'b0, r_t1_c2[DIV_DW-1:32]}, r_t1_ax);
            r_t2_neg1 <= r_t1_neg1;
            r_t2_neg2 <= r_t1_neg2;
            r_t2_dz   <= r_t1_dz;

            r_t3_mid  <= {1'b0, r_t2_a01} + {1'b0, r_t2_a10};
            r_t3_t2   <= {r_t2_b1, 32'b0} + {32'b0, r_t2_b0};
            r_t3_a00  <= r_t2_a00;
            r_t3_a11  <= r_t2_a11;
            r_t3_neg1 <= r_t2_neg1;
            r_t3_neg2 <= r_t2_neg2;
            r_t3_dz   <= r_t2_dz;

            r_t4_t1   <= {r_t3_a11, r_t3_a00} + {31'b0, r_t3_mid, 32'b0};
            r_t4_t2   <= r_t3_t2;
            r_t4_neg1 <= r_t3_neg1;
            r_t4_neg2 <= r_t3_neg2;
            r_t4_dz   <= r_t3_dz;

            // signed terms; a zero x0 with the wrong sign still sums correctly
            r_t5_s1   <= r_t4_neg1 ? (~r_t4_t1 + 1'b1) : r_t4_t1;
            r_t5_s2   <= r_t4_neg2 ? (~{32'b0, r_t4_t2} + 1'b1) : {32'b0, r_t4_t2};
            r_t5_dz   <= r_t4_dz;

            r_t6_acc  <= r_t5_s1 + r_t5_s2;
            r_t6_dz   <= r_t5_dz;

            r_t7_neg  <= r_t6_acc[ACW-1];
            r_t7_mag  <= r_t6_acc[ACW-1] ? (~r_t6_acc + 1'b1) : r_t6_acc;
            r_t7_dz   <= r_t6_dz;

            // half away from zero on the magnitude
            r_t8_rnd  <= r_t7_mag + (ACW'(1) << (FRAC_Q30 - 1));
            r_t8_neg  <= r_t7_neg;
            r_t8_dz   <= r_t7_dz;

            r_out     <= n_out;
        end
    end

    assign o_valid = r_v[NSTG-1];
    assign o_res   = r_out;

endmodule

@@ rtl/ddpm_posterior_mean_core.sv @@
// Top level of the DDPM posterior-mean core: input register, square roots,
// numerator products, dividers and the combine tail. Uses dpm_pkg, dpm_stream_if,
// dpm_isqrt, dpm_div and dpm_tail.
//
//   channel  | dir | payload   | handshake
//   i_in     | in  | t_dpm_in  | valid/ready, taken when both high
//   o_out    | out | t_dpm_out | valid/ready, taken when both high
//
// One item enters per cycle while the output is not held; each result passes through
// 1 input stage, 31 square-root stages, 3 product stages, 63 divider stages
// (one quotient bit each) and 9 combine stages ending in the output register.
// Reset (synchronous, active low) clears only the valid bits.
// The whole pipeline advances whenever the output register is empty or taken;
// a held result freezes every stage, so nothing is lost or repeated.
module ddpm_posterior_mean_core import dpm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dpm_stream_if.sink   i_in,
    dpm_stream_if.source o_out
);

    logic          w_en;
    t_dpm_in       w_in;

    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;
    assign w_in       = i_in.data;

    // ---- S0: input register
    logic             r_s0_v;
    t_dpm_sq_side     r_s0_side;
    logic [SCH_W-1:0] r_s0_one_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (w_en) begin
            r_s0_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_side.x    <= w_in.noisy_sample;
            r_s0_side.eps  <= w_in.predicted_noise;
            r_s0_side.sa   <= w_in.sqrt_abar_now;
            r_s0_side.sp   <= w_in.sqrt_abar_prev;
            r_s0_side.beta <= w_in.noise_rate;
            r_s0_side.om   <= w_in.one_minus_abar_now;
            r_s0_side.omp  <= w_in.one_minus_abar_prev;
            r_s0_side.dz   <= (w_in.sqrt_abar_now == '0) || (w_in.one_minus_abar_now == '0);
            // beta above one leaves nothing of 1-beta
            r_s0_one_mb    <= (w_in.noise_rate > ONE_Q30) ? '0 : (ONE_Q30 - w_in.noise_rate);
        end
    end

    // ---- square roots of (1-abar_t) and (1-beta), both in Q1.30
    logic [1:0][2*SQRT_BITS-1:0] w_rad;
    logic [1:0][SQRT_BITS-1:0]   w_root;
    logic                        w_sq_v;
    t_dpm_sq_side                w_sq_side;

    assign w_rad[0] = {1'b0, r_s0_side.om, {FRAC_Q30{1'b0}}};
    assign w_rad[1] = {1'b0, r_s0_one_mb, {FRAC_Q30{1'b0}}};

    dpm_isqrt #(
        .RW (SQRT_BITS),
        .NL (2),
        .SW ($bits(t_dpm_sq_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s0_v),
        .i_rad   (w_rad),
        .i_side  (r_s0_side),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // ---- S1: products
    logic signed [SQRT_BITS:0] w_som_s;
    logic signed [SMP_W-1:0]   w_eps;

    assign w_som_s = {1'b0, w_root[0]};
    assign w_eps   = w_sq_side.eps;

    logic                    r_s1_v;
    logic signed [63:0]      r_s1_pn;
    logic [2*SCH_W-1:0]      r_s1_p1, r_s1_p2;
    logic signed [SMP_W-1:0] r_s1_x;
    logic [SCH_W-1:0]        r_s1_sa, r_s1_om;
    logic                    r_s1_dz;

    // ---- S2: numerator x*2^30 - sqrt(1-abar_t)*eps
    logic                    r_s2_v;
    logic [63:0]             r_s2_num;
    logic [2*SCH_W-1:0]      r_s2_p1, r_s2_p2;
    logic signed [SMP_W-1:0] r_s2_x;
    logic [SCH_W-1:0]        r_s2_sa, r_s2_om;
    logic                    r_s2_dz;

    // ---- S3: sign and magnitude of the numerator
    logic                    r_s3_v;
    logic                    r_s3_neg;
    logic [DIV_DW-1:0]       r_s3_mag;
    logic [2*SCH_W-1:0]      r_s3_p1, r_s3_p2;
    logic signed [SMP_W-1:0] r_s3_x;
    logic [SCH_W-1:0]        r_s3_sa, r_s3_om;
    logic                    r_s3_dz;

    logic [63:0]             w_num_abs;

    assign w_num_abs = r_s2_num[63] ? (~r_s2_num + 1'b1) : r_s2_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= w_sq_v;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pn  <= w_som_s * w_eps;
            r_s1_p1  <= {{SCH_W{1'b0}}, w_sq_side.sp} * {{SCH_W{1'b0}}, w_sq_side.beta};
            r_s1_p2  <= {{SCH_W{1'b0}}, w_root[1]} * {{SCH_W{1'b0}}, w_sq_side.omp};
            r_s1_x   <= w_sq_side.x;
            r_s1_sa  <= w_sq_side.sa;
            r_s1_om  <= w_sq_side.om;
            r_s1_dz  <= w_sq_side.dz;

            r_s2_num <= {{2{r_s1_x[SMP_W-1]}}, r_s1_x, {FRAC_Q30{1'b0}}} - r_s1_pn;
            r_s2_p1  <= r_s1_p1;
            r_s2_p2  <= r_s1_p2;
            r_s2_x   <= r_s1_x;
            r_s2_sa  <= r_s1_sa;
            r_s2_om  <= r_s1_om;
            r_s2_dz  <= r_s1_dz;

            r_s3_neg <= r_s2_num[63];
            r_s3_mag <= w_num_abs[DIV_DW-1:0];
            r_s3_p1  <= r_s2_p1;
            r_s3_p2  <= r_s2_p2;
            r_s3_x   <= r_s2_x;
            r_s3_sa  <= r_s2_sa;
            r_s3_om  <= r_s2_om;
            r_s3_dz  <= r_s2_dz;
        end
    end

    // ---- dividers: x0 = |num|/sa, c1 = sp*beta/om, c2 = s_1b*omp/om
    logic [2:0][DIV_DW-1:0] w_dvd;
    logic [2:0][DIV_VW-1:0] w_dvs;
    logic [2:0][DIV_DW-1:0] w_quo;
    logic                   w_dv_v;
    t_dpm_dv_side           w_dv_in;
    t_dpm_dv_side           w_dv_side;
    t_dpm_tail_op           w_tail_op;

    assign w_dvd[0] = r_s3_mag;
    assign w_dvd[1] = {{(DIV_DW-2*SCH_W){1'b0}}, r_s3_p1};
    assign w_dvd[2] = {{(DIV_DW-2*SCH_W){1'b0}}, r_s3_p2};
    assign w_dvs[0] = r_s3_sa;
    assign w_dvs[1] = r_s3_om;
    assign w_dvs[2] = r_s3_om;

    assign w_dv_in.neg_num = r_s3_neg;
    assign w_dv_in.x       = r_s3_x;
    assign w_dv_in.dz      = r_s3_dz;

    dpm_div #(
        .DW (DIV_DW),
        .VW (DIV_VW),
        .NL (3),
        .SW ($bits(t_dpm_dv_side))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s3_v),
        .i_dvd   (w_dvd),
        .i_dvs   (w_dvs),
        .i_side  (w_dv_in),
        .o_valid (w_dv_v),
        .o_quo   (w_quo),
        .o_side  (w_dv_side)
    );

    assign w_tail_op.x0_mag = w_quo[0];
    assign w_tail_op.c1     = w_quo[1];
    assign w_tail_op.c2     = w_quo[2];
    assign w_tail_op.neg_x0 = w_dv_side.neg_num;
    assign w_tail_op.x      = w_dv_side.x;
    assign w_tail_op.dz     = w_dv_side.dz;

    dpm_tail u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv_v),
        .i_op    (w_tail_op),
        .o_valid (o_out.valid),
        .o_res   (o_out.data)
    );

    // ---- checks
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.divide_error)
            |-> (o_out.data.posterior_mean == '0 && !o_out.data.saturated))
        else $error("divide error item carries a nonzero mean or a clip flag");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.saturated)
            |-> (o_out.data.posterior_mean == 32'sh7FFF_FFFF
                 || o_out.data.posterior_mean == 32'sh8000_0000))
        else $error("clipped item is not at a Q8.24 bound");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

endmodule
